// ===== sv/qhpm_pkg.sv =====
// ----------------------------------------------------------------------------
// qhpm_pkg: shared types and constants of the quad H-bridge command mapper
// Request and register codes, lane count, scaling constants, stage controls.
// ----------------------------------------------------------------------------
`default_nettype none

package qhpm_pkg;

   // lanes carried by one item, and motors actually present
   localparam int LANES      = 4;
   localparam int NUM_MOTORS = 4;

   // field widths
   localparam int CMD_W  = 16;
   localparam int MAG_W  = CMD_W + 1;   // holds the magnitude 32768
   localparam int NMAG_W = 10;          // normalized magnitude, at most 1000
   localparam int PROD_W = 27;          // 1000 * 65536 fits
   localparam int PM_W   = 16;
   localparam int PINS_W = 2 * LANES;

   // normalized mode: clamp to +-1000 and divide by 1000
   localparam int NORM_MAX = 1000;
   localparam int NORM_MIN = -1000;
   localparam int NORM_DIV = 1000;

   // x / 1000 == (x * RECIP_MULT) >> RECIP_SHIFT for all x below 2**27
   localparam int RECIP_SHIFT = 37;
   localparam int RECIP_W     = 28;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 28'd137438954;
   localparam int QPROD_W     = PROD_W + RECIP_W;

   // request codes; the unused code acts as stop all
   typedef enum logic [1:0] {
      REQ_RAW  = 2'd0,
      REQ_NORM = 2'd1,
      REQ_STOP = 2'd2
   } req_type_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_RUN_ENABLE   = 2'd0,
      CSR_STOP_BRAKE   = 2'd1,
      CSR_INVERT_MASK  = 2'd2,
      CSR_PERIOD_MAX   = 2'd3
   } csr_index_type;

   // bridge pin patterns, bit 0 is IN1
   localparam logic [1:0] PINS_COAST   = 2'b00;
   localparam logic [1:0] PINS_FORWARD = 2'b01;
   localparam logic [1:0] PINS_REVERSE = 2'b10;
   localparam logic [1:0] PINS_BRAKE   = 2'b11;

   // per-stage load enables from the pipeline control
   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
      logic ld4;
   } stage_ld_type;

   // item-wide controls handed to every lane
   typedef struct packed {
      logic       stopping;
      logic       norm;
      logic [1:0] stop_pins;
   } lane_ctl_type;

endpackage

`default_nettype wire

// ===== sv/qhpm_lane.sv =====
// ----------------------------------------------------------------------------
// qhpm_lane: one motor's command path
// Clamp, invert, sign to pins, magnitude, per-mille scaling by reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module qhpm_lane (
   input  wire logic                           clock,
   input  wire qhpm_pkg::stage_ld_type         ld,
   input  wire qhpm_pkg::lane_ctl_type         ctl,
   input  wire logic                           active,
   input  wire logic                           invert,
   input  wire logic [qhpm_pkg::PM_W-1:0]      period_max,
   input  wire logic signed [qhpm_pkg::CMD_W-1:0] command,
   output logic [qhpm_pkg::MAG_W-1:0]          val,
   output logic [1:0]                          pins
);

   localparam logic signed [qhpm_pkg::MAG_W-1:0] HI =
      qhpm_pkg::MAG_W'(qhpm_pkg::NORM_MAX);
   localparam logic signed [qhpm_pkg::MAG_W-1:0] LO =
      qhpm_pkg::MAG_W'(qhpm_pkg::NORM_MIN);

   logic signed [qhpm_pkg::MAG_W-1:0] v_ext;
   logic signed [qhpm_pkg::MAG_W-1:0] v_clamp;
   logic signed [qhpm_pkg::MAG_W-1:0] v_inv;
   logic        v_neg;
   logic        v_zero;
   logic [qhpm_pkg::MAG_W-1:0] mag;
   logic [1:0]  pins_s1;

   logic [qhpm_pkg::MAG_W-1:0]  mag1_ff, mag1_in;
   logic [1:0]                  pins1_ff, pins1_in;
   logic                        norm1_ff, norm1_in;

   logic [qhpm_pkg::MAG_W-1:0]  pm_p1;
   logic [qhpm_pkg::PROD_W-1:0] prod2_ff, prod2_in;
   logic [qhpm_pkg::MAG_W-1:0]  mag2_ff, mag2_in;
   logic [1:0]                  pins2_ff, pins2_in;
   logic                        norm2_ff, norm2_in;

   logic [qhpm_pkg::QPROD_W-1:0] qprod;
   logic [qhpm_pkg::MAG_W-1:0]  val3_ff, val3_in;
   logic [1:0]                  pins3_ff, pins3_in;

   // stage 1: clamp, invert, sign and magnitude
   always_comb begin
      v_ext = qhpm_pkg::MAG_W'(command);
      if (ctl.norm && (v_ext > HI)) begin
         v_clamp = HI;
      end else if (ctl.norm && (v_ext < LO)) begin
         v_clamp = LO;
      end else begin
         v_clamp = v_ext;
      end
      v_inv  = invert ? -v_clamp : v_clamp;
      v_neg  = v_inv[qhpm_pkg::MAG_W-1];
      v_zero = (v_inv == '0);
      mag    = v_neg ? qhpm_pkg::MAG_W'(-v_inv) : qhpm_pkg::MAG_W'(v_inv);

      if (!active) begin
         pins_s1 = qhpm_pkg::PINS_COAST;
      end else if (ctl.stopping || v_zero) begin
         pins_s1 = ctl.stop_pins;
      end else if (v_neg) begin
         pins_s1 = qhpm_pkg::PINS_REVERSE;
      end else begin
         pins_s1 = qhpm_pkg::PINS_FORWARD;
      end

      mag1_in  = (ctl.stopping || !active) ? '0 : mag;
      pins1_in = pins_s1;
      norm1_in = ctl.norm;
   end

   // stage 2: normalized magnitude times (period_max + 1)
   always_comb begin
      pm_p1    = qhpm_pkg::MAG_W'({1'b0, period_max}) + qhpm_pkg::MAG_W'(1);
      prod2_in = qhpm_pkg::PROD_W'(mag1_ff[qhpm_pkg::NMAG_W-1:0])
               * qhpm_pkg::PROD_W'(pm_p1);
      mag2_in  = mag1_ff;
      pins2_in = pins1_ff;
      norm2_in = norm1_ff;
   end

   // stage 3: divide by 1000 through the reciprocal, pick raw or scaled
   always_comb begin
      qprod    = qhpm_pkg::QPROD_W'(prod2_ff)
               * qhpm_pkg::QPROD_W'(qhpm_pkg::RECIP_MULT);
      val3_in  = norm2_ff
               ? qprod[qhpm_pkg::RECIP_SHIFT +: qhpm_pkg::MAG_W]
               : mag2_ff;
      pins3_in = pins2_ff;
   end

   always_ff @(posedge clock) begin
      if (ld.ld1) begin
         mag1_ff  <= mag1_in;
         pins1_ff <= pins1_in;
         norm1_ff <= norm1_in;
      end
      if (ld.ld2) begin
         prod2_ff <= prod2_in;
         mag2_ff  <= mag2_in;
         pins2_ff <= pins2_in;
         norm2_ff <= norm2_in;
      end
      if (ld.ld3) begin
         val3_ff  <= val3_in;
         pins3_ff <= pins3_in;
      end
   end

   assign val  = val3_ff;
   assign pins = pins3_ff;

endmodule

`default_nettype wire

// ===== sv/qhpm_merge.sv =====
// ----------------------------------------------------------------------------
// qhpm_merge: result stage
// Limits every lane's count to period_max and packs the bridge pins.
// ----------------------------------------------------------------------------
`default_nettype none

module qhpm_merge (
   input  wire logic                          clock,
   input  wire qhpm_pkg::stage_ld_type        ld,
   input  wire logic [qhpm_pkg::PM_W-1:0]     period_max,
   input  wire logic [qhpm_pkg::MAG_W-1:0]    lane_val  [qhpm_pkg::LANES],
   input  wire logic [1:0]                    lane_pins [qhpm_pkg::LANES],
   output logic [qhpm_pkg::PINS_W-1:0]        bridge_pins,
   output logic [qhpm_pkg::PM_W-1:0]          compare [qhpm_pkg::LANES]
);

   logic [qhpm_pkg::PINS_W-1:0] pins_ff, pins_in;
   logic [qhpm_pkg::PM_W-1:0]   cmp_ff [qhpm_pkg::LANES];
   logic [qhpm_pkg::PM_W-1:0]   cmp_in [qhpm_pkg::LANES];

   // clamp each lane and gather pins
   always_comb begin
      for (int i = 0; i < qhpm_pkg::LANES; i++) begin
         cmp_in[i] = (lane_val[i] > qhpm_pkg::MAG_W'(period_max))
                   ? period_max
                   : lane_val[i][qhpm_pkg::PM_W-1:0];
         pins_in[2*i +: 2] = lane_pins[i];
      end
   end

   always_ff @(posedge clock) begin
      if (ld.ld4) begin
         pins_ff <= pins_in;
         cmp_ff  <= cmp_in;
      end
   end

   assign bridge_pins = pins_ff;
   assign compare     = cmp_ff;

endmodule

`default_nettype wire

// ===== sv/quad_hbridge_pwm_command_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// quad_hbridge_pwm_command_mapper_unit: four-motor sign/magnitude PWM mapper
// Maps one set of motor commands to H-bridge pins and PWM compare counts.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : input items (request type and four signed commands), taken at
//            an edge with req_valid high and req_stall low.
//   rsp_*  : result items (bridge pins and four compare counts), taken at an
//            edge with rsp_valid high and rsp_stall low.
//   csr_*  : register writes (index, data); csr_ready is always high. Write
//            only while no item is in flight.
// Pipeline: four registers, front end (loaded at the edge that accepts an
// item), scaling multiply, reciprocal multiply for the divide by 1000 and
// result register. rsp_valid rises when an item loads the result register.
// Throughput is one item per cycle while no result stalls; the four lanes
// run in parallel and the reciprocal multiply sets the stage depth.
// A stalled result holds; stages behind it keep filling (up to four items
// in flight) before req_stall rises.
// Reset empties the pipeline and loads run_enable=1, stop_brake=0,
// invert_mask=0, period_max=8399.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_hbridge_pwm_command_mapper_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic signed [15:0] req_m1_command,
   input  wire logic signed [15:0] req_m2_command,
   input  wire logic signed [15:0] req_m3_command,
   input  wire logic signed [15:0] req_m4_command,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_bridge_pins,
   output logic [15:0]      rsp_m1_compare,
   output logic [15:0]      rsp_m2_compare,
   output logic [15:0]      rsp_m3_compare,
   output logic [15:0]      rsp_m4_compare,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   // registers
   logic        run_enable_ff, run_enable_in;
   logic        stop_brake_ff, stop_brake_in;
   logic [qhpm_pkg::LANES-1:0] invert_mask_ff, invert_mask_in;
   logic [qhpm_pkg::PM_W-1:0]  period_max_ff, period_max_in;

   // pipeline occupancy
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, vout_ff, vout_in;
   logic rdy1, rdy2, rdy3, rdy4;
   qhpm_pkg::stage_ld_type ld;
   qhpm_pkg::lane_ctl_type ctl;

   logic signed [qhpm_pkg::CMD_W-1:0] cmd [qhpm_pkg::LANES];
   logic [qhpm_pkg::MAG_W-1:0] lane_val  [qhpm_pkg::LANES];
   logic [1:0]                 lane_pins [qhpm_pkg::LANES];
   logic [qhpm_pkg::PM_W-1:0]  compare   [qhpm_pkg::LANES];

   // register write decode
   assign csr_ready = 1'b1;

   always_comb begin
      run_enable_in   = run_enable_ff;
      stop_brake_in   = stop_brake_ff;
      invert_mask_in  = invert_mask_ff;
      period_max_in   = period_max_ff;
      if (csr_valid && csr_ready) begin
         case (qhpm_pkg::csr_index_type'(csr_index))
            qhpm_pkg::CSR_RUN_ENABLE:   run_enable_in   = csr_data[0];
            qhpm_pkg::CSR_STOP_BRAKE:   stop_brake_in   = csr_data[0];
            qhpm_pkg::CSR_INVERT_MASK:  invert_mask_in  = csr_data[qhpm_pkg::LANES-1:0];
            qhpm_pkg::CSR_PERIOD_MAX:   period_max_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_enable_ff   <= 1'b1;
         stop_brake_ff   <= 1'b0;
         invert_mask_ff  <= '0;
         period_max_ff   <= 16'd8399;
      end else begin
         run_enable_ff   <= run_enable_in;
         stop_brake_ff   <= stop_brake_in;
         invert_mask_ff  <= invert_mask_in;
         period_max_ff   <= period_max_in;
      end
   end

   // stage handshake: a stage loads when it is empty or its item moves on
   always_comb begin
      rdy4   = !vout_ff || !rsp_stall;
      rdy3   = !v3_ff || rdy4;
      rdy2   = !v2_ff || rdy3;
      rdy1   = !v1_ff || rdy2;
      ld.ld4 = v3_ff && rdy4;
      ld.ld3 = v2_ff && rdy3;
      ld.ld2 = v1_ff && rdy2;
      ld.ld1 = req_valid && rdy1;

      v1_in   = ld.ld1 ? 1'b1 : (ld.ld2 ? 1'b0 : v1_ff);
      v2_in   = ld.ld2 ? 1'b1 : (ld.ld3 ? 1'b0 : v2_ff);
      v3_in   = ld.ld3 ? 1'b1 : (ld.ld4 ? 1'b0 : v3_ff);
      vout_in = ld.ld4 ? 1'b1 : ((vout_ff && !rsp_stall) ? 1'b0 : vout_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         vout_ff <= 1'b0;
      end else begin
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         v3_ff   <= v3_in;
         vout_ff <= vout_in;
      end
   end

   assign req_stall = !rdy1;
   assign rsp_valid = vout_ff;

   // item-wide controls
   always_comb begin
      ctl.norm      = (req_type == qhpm_pkg::REQ_NORM) && run_enable_ff;
      ctl.stopping  = !run_enable_ff
                    || ((req_type != qhpm_pkg::REQ_RAW)
                        && (req_type != qhpm_pkg::REQ_NORM));
      ctl.stop_pins = stop_brake_ff ? qhpm_pkg::PINS_BRAKE : qhpm_pkg::PINS_COAST;
   end

   assign cmd[0] = req_m1_command;
   assign cmd[1] = req_m2_command;
   assign cmd[2] = req_m3_command;
   assign cmd[3] = req_m4_command;

   // motor lanes
   for (genvar i = 0; i < qhpm_pkg::LANES; i++) begin : g_lane
      qhpm_lane u_lane (
         .clock      (clock),
         .ld         (ld),
         .ctl        (ctl),
         .active     (1'(i < qhpm_pkg::NUM_MOTORS)),
         .invert     (invert_mask_ff[i]),
         .period_max (period_max_ff),
         .command    (cmd[i]),
         .val        (lane_val[i]),
         .pins       (lane_pins[i])
      );
   end

   // result stage
   qhpm_merge u_merge (
      .clock       (clock),
      .ld          (ld),
      .period_max  (period_max_ff),
      .lane_val    (lane_val),
      .lane_pins   (lane_pins),
      .bridge_pins (rsp_bridge_pins),
      .compare     (compare)
   );

   assign rsp_m1_compare = compare[0];
   assign rsp_m2_compare = compare[1];
   assign rsp_m3_compare = compare[2];
   assign rsp_m4_compare = compare[3];

`ifndef NO_ASSERTIONS
   // an empty pipeline never stalls the sender
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      (!v1_ff && !v2_ff && !v3_ff && !vout_ff) |-> !req_stall)
      else $error("stall with empty pipeline");

   // an item in stage 1 that cannot move stays put
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !ld.ld2) |=> v1_ff)
      else $error("item dropped from stage 1");

   // counts never exceed the timer period
   a_cmp_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_m1_compare <= period_max_ff)
                  && (rsp_m2_compare <= period_max_ff)
                  && (rsp_m3_compare <= period_max_ff)
                  && (rsp_m4_compare <= period_max_ff)))
      else $error("compare above period_max");

   // a running motor 1 drives one pin only
   a_drive_pins: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_m1_compare != 16'd0))
      |-> ((rsp_bridge_pins[1:0] == qhpm_pkg::PINS_FORWARD)
        || (rsp_bridge_pins[1:0] == qhpm_pkg::PINS_REVERSE)))
      else $error("nonzero compare with stop pins");
`endif

endmodule

`default_nettype wire

// ===== bench/quad_hbridge_pwm_command_mapper_unit_tb.sv =====
// ----------------------------------------------------------------------------
// quad_hbridge_pwm_command_mapper_unit_tb: self-checking bench of the mapper
// Drives request items with random gaps and result stalls, predicts bridge
// pins and compare counts per item, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quad_hbridge_pwm_command_mapper_unit_tb;

   // unused request code, behaves as stop all
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [qhpm_pkg::PINS_W-1:0]                    pins;
      logic [qhpm_pkg::LANES-1:0][qhpm_pkg::PM_W-1:0] cmp;
   } bridge_result_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_type;
   logic signed [15:0] req_m1_command, req_m2_command, req_m3_command, req_m4_command;
   logic rsp_valid;
   logic rsp_stall;
   logic [7:0] rsp_bridge_pins;
   logic [15:0] rsp_m1_compare, rsp_m2_compare, rsp_m3_compare, rsp_m4_compare;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [15:0] csr_data;

   // register copies seen by the predictor
   logic        drive_enable;
   logic        brake_on_zero;
   logic [3:0]  invert_bits;
   logic [15:0] period_count;

   bridge_result_type pending_results[$];
   int fail_count = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int stall_left = 0;
   bit quiet = 1'b0;
   bit send_calm = 1'b0;
   bit stall_calm = 1'b0;

   quad_hbridge_pwm_command_mapper_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_m1_command(req_m1_command),
      .req_m2_command(req_m2_command),
      .req_m3_command(req_m3_command),
      .req_m4_command(req_m4_command),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_bridge_pins(rsp_bridge_pins),
      .rsp_m1_compare(rsp_m1_compare),
      .rsp_m2_compare(rsp_m2_compare),
      .rsp_m3_compare(rsp_m3_compare),
      .rsp_m4_compare(rsp_m4_compare),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // expected pins and compares for one command set
   function automatic bridge_result_type map_commands(logic [1:0] req,
      logic [qhpm_pkg::LANES-1:0][15:0] cmds);
      bridge_result_type r;
      logic stopping;
      logic [1:0] stop_pat;
      int v;
      longint mag;
      r = '0;
      stopping = !drive_enable || (req >= qhpm_pkg::REQ_STOP);
      stop_pat = brake_on_zero ? qhpm_pkg::PINS_BRAKE : qhpm_pkg::PINS_COAST;
      for (int i = 0; i < qhpm_pkg::LANES; i++) begin
         if (i < qhpm_pkg::NUM_MOTORS) begin
            if (stopping) begin
               r.pins[2*i +: 2] = stop_pat;
            end else begin
               v = $signed(cmds[i]);
               if (req == qhpm_pkg::REQ_NORM) begin
                  if (v > qhpm_pkg::NORM_MAX) v = qhpm_pkg::NORM_MAX;
                  if (v < qhpm_pkg::NORM_MIN) v = qhpm_pkg::NORM_MIN;
               end
               if (invert_bits[i]) v = -v;
               if (v > 0) r.pins[2*i +: 2] = qhpm_pkg::PINS_FORWARD;
               else if (v < 0) r.pins[2*i +: 2] = qhpm_pkg::PINS_REVERSE;
               else r.pins[2*i +: 2] = stop_pat;
               mag = (v < 0) ? -v : v;
               if (req == qhpm_pkg::REQ_NORM)
                  mag = (mag * (longint'(period_count) + 1)) / qhpm_pkg::NORM_DIV;
               r.cmp[i] = (mag > period_count) ? period_count : mag[15:0];
            end
         end
      end
      return r;
   endfunction

   // one register write; valid drops for a cycle afterwards
   task automatic write_register(qhpm_pkg::csr_index_type idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         qhpm_pkg::CSR_RUN_ENABLE:  drive_enable  = data[0];
         qhpm_pkg::CSR_STOP_BRAKE:  brake_on_zero = data[0];
         qhpm_pkg::CSR_INVERT_MASK: invert_bits   = data[3:0];
         qhpm_pkg::CSR_PERIOD_MAX:  period_count  = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // send one command item, with an occasional idle burst ahead of it
   task automatic send_item(logic [1:0] req, int c1, int c2, int c3, int c4);
      if (items_sent % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
      if (!quiet && !send_calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= req;
      req_m1_command <= 16'(c1);
      req_m2_command <= 16'(c2);
      req_m3_command <= 16'(c3);
      req_m4_command <= 16'(c4);
      do @(posedge clock); while (req_stall);
      pending_results.push_back(map_commands(req,
         {16'(c4), 16'(c3), 16'(c2), 16'(c1)}));
      items_sent++;
   endtask

   // wait until every result is back, then let the pipeline settle
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] random_command();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h8001;
               3: return 16'h0000;
               4: return 16'h0001;
               default: return 16'hFFFF;
            endcase
         end
         1, 2, 3: return 16'($signed($urandom_range(0, 2200)) - 1100);
         4: return 16'($signed($urandom_range(0, 10)) - 5);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [1:0] random_request();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return qhpm_pkg::REQ_RAW;
         4, 5, 6, 7: return qhpm_pkg::REQ_NORM;
         8: return qhpm_pkg::REQ_STOP;
         default: return REQ_UNUSED;
      endcase
   endfunction

   // reset values: enabled, coast, no inversion, period 8399
   task automatic test_reset_defaults;
      send_item(qhpm_pkg::REQ_RAW, 32767, -32768, 0, 1);
      send_item(qhpm_pkg::REQ_RAW, -1, 8399, 8400, -32767);
      send_item(qhpm_pkg::REQ_NORM, 1000, -1000, 1001, -32768);
      send_item(qhpm_pkg::REQ_NORM, 500, -1, 0, 32767);
      send_item(qhpm_pkg::REQ_STOP, 100, -100, 0, 5);
      send_item(REQ_UNUSED, 1, 2, 3, 4);
      drain();
   endtask

   // brake on zero and inverted motors 2 and 4, most negative inverted too
   task automatic test_brake_invert;
      write_register(qhpm_pkg::CSR_STOP_BRAKE, 16'd1);
      write_register(qhpm_pkg::CSR_INVERT_MASK, 16'b1010);
      send_item(qhpm_pkg::REQ_RAW, 0, 0, 0, 0);
      send_item(qhpm_pkg::REQ_RAW, -32768, -32768, 5, -5);
      send_item(qhpm_pkg::REQ_NORM, -1000, 1000, 1, -1);
      send_item(qhpm_pkg::REQ_STOP, 1, 1, 1, 1);
      drain();
   endtask

   // disabled block forces stop pattern and zero compares
   task automatic test_disable;
      write_register(qhpm_pkg::CSR_RUN_ENABLE, 16'd0);
      send_item(qhpm_pkg::REQ_RAW, 100, -100, 0, 32767);
      send_item(qhpm_pkg::REQ_NORM, 1000, -1000, 7, -7);
      drain();
      write_register(qhpm_pkg::CSR_STOP_BRAKE, 16'd0);
      send_item(qhpm_pkg::REQ_RAW, 1, -1, 0, -32768);
      drain();
      write_register(qhpm_pkg::CSR_RUN_ENABLE, 16'd1);
   endtask

   // zero period: compares all zero, pins still follow sign
   task automatic test_zero_period;
      write_register(qhpm_pkg::CSR_INVERT_MASK, 16'd0);
      write_register(qhpm_pkg::CSR_PERIOD_MAX, 16'd0);
      send_item(qhpm_pkg::REQ_RAW, 5, -5, 0, 32767);
      send_item(qhpm_pkg::REQ_NORM, 1000, -1000, 0, 1);
      drain();
   endtask

   // full 16-bit period, normalized full scale saturates
   task automatic test_full_period;
      write_register(qhpm_pkg::CSR_PERIOD_MAX, 16'hFFFF);
      send_item(qhpm_pkg::REQ_RAW, -32768, 32767, 65535, 1);
      send_item(qhpm_pkg::REQ_NORM, 1000, 999, -1, -1000);
      send_item(qhpm_pkg::REQ_NORM, -32768, 32767, 1, 0);
      drain();
   endtask

   // random settings per phase, random traffic; last phase without idling
   task automatic test_random_traffic(int total);
      int per_phase;
      logic [15:0] period;
      per_phase = total / 6;
      for (int p = 0; p < 6; p++) begin
         if (p == 5) quiet = 1'b1;
         case ($urandom_range(0, 5))
            0: period = 16'd0;
            1: period = 16'hFFFF;
            2: period = 16'd8399;
            3: period = 16'($urandom_range(1, 20));
            default: period = 16'($urandom);
         endcase
         write_register(qhpm_pkg::CSR_RUN_ENABLE,
                        {15'($urandom), ($urandom_range(0, 4) != 0)});
         write_register(qhpm_pkg::CSR_STOP_BRAKE, 16'($urandom));
         write_register(qhpm_pkg::CSR_INVERT_MASK, 16'($urandom));
         write_register(qhpm_pkg::CSR_PERIOD_MAX, period);
         for (int k = 0; k < per_phase; k++)
            send_item(random_request(), random_command(), random_command(),
                      random_command(), random_command());
         drain();
      end
   endtask

   // result stalls in bursts, with calm windows
   always @(posedge clock) begin
      if (cycle_count % 128 == 0) stall_calm = ($urandom_range(0, 3) == 0);
      if (reset || quiet || stall_calm) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // cycle count and timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("quad_hbridge_pwm_command_mapper_unit_tb: done, errors");
         $finish;
      end
   end

   task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch %s: expected %h, got %h at cycle %0d",
                     what, want, got, cycle_count);
      end
   endtask

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_results
      bridge_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result at cycle %0d", cycle_count);
         end else begin
            want = pending_results.pop_front();
            check_field("bridge_pins", {8'd0, rsp_bridge_pins}, {8'd0, want.pins});
            check_field("m1_compare", rsp_m1_compare, want.cmp[0]);
            check_field("m2_compare", rsp_m2_compare, want.cmp[1]);
            check_field("m3_compare", rsp_m3_compare, want.cmp[2]);
            check_field("m4_compare", rsp_m4_compare, want.cmp[3]);
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = qhpm_pkg::REQ_RAW;
      req_m1_command = '0;
      req_m2_command = '0;
      req_m3_command = '0;
      req_m4_command = '0;
      csr_valid      = 1'b0;
      csr_index      = qhpm_pkg::CSR_RUN_ENABLE;
      csr_data       = '0;
      drive_enable   = 1'b1;
      brake_on_zero  = 1'b0;
      invert_bits    = 4'd0;
      period_count   = 16'd8399;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_brake_invert();
      test_disable();
      test_zero_period();
      test_full_period();
      test_random_traffic(2000);

      if (pending_results.size() != 0) fail_count++;
      if (fail_count == 0)
         $display("quad_hbridge_pwm_command_mapper_unit_tb: done, clean");
      else
         $display("quad_hbridge_pwm_command_mapper_unit_tb: done, errors");
      $finish;
   end

endmodule
